[design/pdbh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbh_pkg
// Shared constants and types for the display byte converter and histogram.
// ----------------------------------------------------------------------------
package pdbh_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SCALE_FRAC_DEF  = 16;

  localparam int SAMPLE_W   = 32;
  localparam int BYTE_W     = 8;
  localparam int BIN_W      = 8;
  localparam int NUM_BINS   = 256;
  localparam int FACTOR_W   = 24;
  localparam int RESULT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = SAMPLE_W + FACTOR_W;

  // operation codes
  localparam logic [1:0] OP_CONVERT = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // sample types
  localparam logic [1:0] TYPE_S8  = 2'd0;
  localparam logic [1:0] TYPE_S16 = 2'd1;

  // conversion modes
  localparam logic [1:0] MODE_BITS  = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLLECT      = 3'd7;

  localparam logic [BYTE_W-1:0]   BYTE_MAX       = 8'hFF;
  localparam logic [4:0]          HIGH_BIT_RST   = 5'd7;
  localparam logic [SAMPLE_W-1:0] SCALE_HIGH_RST = 32'd255;
  localparam logic [FACTOR_W-1:0] FACTOR_RST     = 24'd65536;

  typedef struct packed {
    logic [1:0]          sample_type;
    logic [1:0]          mode;
    logic [4:0]          low_bit;
    logic [4:0]          high_bit;
    logic [SAMPLE_W-1:0] scale_low;
    logic [SAMPLE_W-1:0] scale_high;
    logic [FACTOR_W-1:0] scale_factor;
  } conv_cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [BIN_W-1:0] addr;
  } hist_cmd_t;

endpackage

[design/pixel_to_display_byte_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_display_byte_histogram
// Converts signed samples to display bytes and keeps a 256-bin histogram.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time: a convert passes through the
// four-stage convert path and, with histogram collection, the histogram
// read-modify-write; a bin read passes through the registered histogram read.
// The next transaction is taken once the result has moved to the output
// register, which waits while the output register holds an untaken result.
// Reset restores register defaults and marks all bins zero at once.
module pixel_to_display_byte_histogram #(
  parameter int COUNT_WIDTH     = pdbh_pkg::COUNT_WIDTH_DEF,
  parameter int SCALE_FRAC_BITS = pdbh_pkg::SCALE_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pdbh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdbh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // sample, bin_index
  input  logic [1:0]                      s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata   // display_byte, bin_count
);
  import pdbh_pkg::*;

  localparam int CntExtW = (COUNT_WIDTH > RESULT_W) ? COUNT_WIDTH : RESULT_W;

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_INCR, S_READ, S_DONE} state_e;

  state_e                 state_q, state_d;
  conv_cfg_t              cfg_q;
  logic                   collect_q;
  hist_cmd_t              hcmd;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [CntExtW-1:0]     cnt_ext;
  logic                   accept;
  logic [1:0]             in_op;
  logic                   conv_start;
  logic                   conv_vld;
  logic [BYTE_W-1:0]      conv_byte;

  logic [BYTE_W-1:0]      res_byte_q, res_byte_d;
  logic [RESULT_W-1:0]    res_cnt_q, res_cnt_d;
  logic                   out_vld_q, out_vld_d;
  logic [BYTE_W-1:0]      out_byte_q, out_byte_d;
  logic [RESULT_W-1:0]    out_cnt_q, out_cnt_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser;
  assign conv_start    = accept && (in_op == OP_CONVERT);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_type  <= '0;
      cfg_q.mode         <= '0;
      cfg_q.low_bit      <= '0;
      cfg_q.high_bit     <= HIGH_BIT_RST;
      cfg_q.scale_low    <= '0;
      cfg_q.scale_high   <= SCALE_HIGH_RST;
      cfg_q.scale_factor <= FACTOR_RST;
      collect_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_TYPE:  cfg_q.sample_type  <= cfg_wdata_i[1:0];
        REG_CONV_MODE:    cfg_q.mode         <= cfg_wdata_i[1:0];
        REG_LOW_BIT:      cfg_q.low_bit      <= cfg_wdata_i[4:0];
        REG_HIGH_BIT:     cfg_q.high_bit     <= cfg_wdata_i[4:0];
        REG_SCALE_LOW:    cfg_q.scale_low    <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_SCALE_HIGH:   cfg_q.scale_high   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_wdata_i[FACTOR_W-1:0];
        REG_COLLECT:      collect_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pdbh_convert #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_vld_i (conv_start),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .out_vld_o(conv_vld),
    .byte_o   (conv_byte)
  );

  pdbh_hist #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (hcmd),
    .wr_data_i (wr_count),
    .rd_count_o(rd_count)
  );

  assign wr_count = rd_count + COUNT_WIDTH'(1);
  assign cnt_ext  = CntExtW'(rd_count);

  always_comb begin
    state_d    = state_q;
    res_byte_d = res_byte_q;
    res_cnt_d  = res_cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_byte_d = out_byte_q;
    out_cnt_d  = out_cnt_q;
    hcmd       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_byte_d = '0;
          res_cnt_d  = '0;
          case (in_op)
            OP_CONVERT: state_d = S_CONV;
            OP_READ: begin
              hcmd.rd_en = 1'b1;
              hcmd.addr  = s_axis_tdata[SAMPLE_W +: BIN_W];
              state_d    = S_READ;
            end
            OP_CLEAR: begin
              hcmd.clr = 1'b1;
              state_d  = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CONV: begin
        if (conv_vld) begin
          res_byte_d = conv_byte;
          if (collect_q) begin
            hcmd.rd_en = 1'b1;
            hcmd.addr  = conv_byte;
            state_d    = S_INCR;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_INCR: begin
        // read data of the bin is back, write the incremented count
        hcmd.wr_en = 1'b1;
        hcmd.addr  = res_byte_q;
        state_d    = S_DONE;
      end
      S_READ: begin
        res_cnt_d = cnt_ext[RESULT_W-1:0];
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_byte_d = res_byte_q;
          out_cnt_d  = res_cnt_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_byte_q <= res_byte_d;
    res_cnt_q  <= res_cnt_d;
    out_byte_q <= out_byte_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_byte_q};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("transaction accepted while another is in flight");

  a_conv_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_vld |-> (state_q == S_CONV))
    else $error("converter result outside convert state");

  a_hist_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hcmd.rd_en && hcmd.wr_en) && !(hcmd.clr && (hcmd.rd_en || hcmd.wr_en)))
    else $error("overlapping histogram accesses");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_cnt_q != '0)) |-> (out_byte_q == '0))
    else $error("result carries both a byte and a count");

  a_incr_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INCR) |-> $past(hcmd.rd_en))
    else $error("increment without a preceding bin read");

endmodule

[design/pdbh_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbh_convert
// Four-stage sample to display byte path: sign extension, clamp or bit range
// extraction, offset subtract, fixed-point multiply and saturation.
// ----------------------------------------------------------------------------
module pdbh_convert #(
  parameter int SCALE_FRAC_BITS = pdbh_pkg::SCALE_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdbh_pkg::conv_cfg_t             cfg_i,
  input  logic                            in_vld_i,
  input  logic [pdbh_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                            out_vld_o,
  output logic [pdbh_pkg::BYTE_W-1:0]     byte_o
);
  import pdbh_pkg::*;

  localparam int QW = PROD_W - SCALE_FRAC_BITS;

  logic signed [SAMPLE_W-1:0] sext;
  logic signed [SAMPLE_W-1:0] clamped;
  logic signed [SAMPLE_W-1:0] shifted;
  logic [5:0]                 nbits;
  logic [BYTE_W-1:0]          mask8;
  logic [BYTE_W-1:0]          byte1_d;
  logic [SAMPLE_W:0]          diff;
  logic [PROD_W-1:0]          prod_d;
  logic [QW-1:0]              quot;

  logic                       v1_q, v2_q, v3_q;
  logic                       scale1_q, scale2_q, scale3_q;
  logic [BYTE_W-1:0]          byte1_q, byte2_q, byte3_q;
  logic signed [SAMPLE_W-1:0] clamp1_q;
  logic                       neg2_q;
  logic [SAMPLE_W-1:0]        d2_q;
  logic [PROD_W-1:0]          prod3_q;

  // stage 1: sign extension, clamp, bit range extraction
  always_comb begin
    case (cfg_i.sample_type)
      TYPE_S8:  sext = {{(SAMPLE_W-8){sample_i[7]}}, sample_i[7:0]};
      TYPE_S16: sext = {{(SAMPLE_W-16){sample_i[15]}}, sample_i[15:0]};
      default:  sext = sample_i;
    endcase

    clamped = sext;
    if (clamped < $signed(cfg_i.scale_low)) clamped = $signed(cfg_i.scale_low);
    if (clamped > $signed(cfg_i.scale_high)) clamped = $signed(cfg_i.scale_high);

    shifted = sext >>> cfg_i.low_bit;
    nbits   = 6'(cfg_i.high_bit) - 6'(cfg_i.low_bit) + 6'd1;
    for (int k = 0; k < BYTE_W; k++) begin
      mask8[k] = (6'(k) < nbits);
    end

    case (cfg_i.mode)
      MODE_BITS: begin
        if (cfg_i.high_bit < cfg_i.low_bit) byte1_d = '0;
        else byte1_d = shifted[BYTE_W-1:0] & mask8;
      end
      default: byte1_d = sample_i[BYTE_W-1:0];
    endcase
  end

  // stage 2: offset from the lower bound, exact in 33 bits
  assign diff = {clamp1_q[SAMPLE_W-1], clamp1_q} -
                {cfg_i.scale_low[SAMPLE_W-1], cfg_i.scale_low};

  // stage 3: fixed-point multiply, negative offsets give zero
  assign prod_d = neg2_q ? '0 : (PROD_W'(d2_q) * PROD_W'(cfg_i.scale_factor));

  // stage 4: truncate fraction and saturate
  assign quot      = prod3_q[PROD_W-1:SCALE_FRAC_BITS];
  assign out_vld_o = v3_q;
  assign byte_o    = !scale3_q ? byte3_q :
                     (|quot[QW-1:BYTE_W]) ? BYTE_MAX : quot[BYTE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scale1_q <= (cfg_i.mode == MODE_SCALE);
    byte1_q  <= byte1_d;
    clamp1_q <= clamped;
    scale2_q <= scale1_q;
    byte2_q  <= byte1_q;
    neg2_q   <= diff[SAMPLE_W];
    d2_q     <= diff[SAMPLE_W-1:0];
    scale3_q <= scale2_q;
    byte3_q  <= byte2_q;
    prod3_q  <= prod_d;
  end

endmodule

[design/pdbh_hist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbh_hist
// 256-bin count memory with registered read, per-bin valid flags
// and a clear that resets all valid flags at once.
// ----------------------------------------------------------------------------
module pdbh_hist #(
  parameter int COUNT_WIDTH = pdbh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pdbh_pkg::hist_cmd_t    cmd_i,
  input  logic [COUNT_WIDTH-1:0] wr_data_i,
  output logic [COUNT_WIDTH-1:0] rd_count_o
);
  import pdbh_pkg::*;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]    vld_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.addr] <= wr_data_i;
    if (cmd_i.rd_en) rd_q <= mem_q[cmd_i.addr];
  end

  // a bin never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) vld_q <= '0;
      else if (cmd_i.wr_en) vld_q[cmd_i.addr] <= 1'b1;
      if (cmd_i.rd_en) rd_vld_q <= vld_q[cmd_i.addr];
    end
  end

  assign rd_count_o = rd_vld_q ? rd_q : '0;

endmodule
